### src/clt_pkg.sv
package clt_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RESULTS = 3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ASCII_MAX = 8'h7F;

    localparam logic REG_HIGH_BYTES_BLANK = 1'b0;

    typedef enum logic [2:0] {
        MODE_BETWEEN,
        MODE_BARE,
        MODE_QUOTED,
        MODE_COMMENT,
        MODE_IGNORE
    } mode_t;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_END,
        KIND_DONE
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tok_byte;
        logic [5:0]  token_index;
        logic [6:0]  token_count;
    } result_t;

    typedef struct packed {
        logic [1:0]                    count;
        result_t [MAX_RESULTS-1:0]     res;
    } bundle_t;

endpackage

### src/clt_front.sv
module clt_front #(
    parameter int MAX_TOKENS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               high_bytes_blank,
    input  logic               accept,
    input  logic [7:0]         ch,
    input  logic               line_end,
    output logic               bundle_valid,
    output clt_pkg::bundle_t   bundle
);

    localparam int TW = $clog2(MAX_TOKENS + 1);

    clt_pkg::mode_t  mode_reg, mode_next;
    logic            slash_reg, slash_next;
    logic            star_reg, star_next;
    logic [TW-1:0]   tsf_reg, tsf_next;
    logic            do_bare;
    logic            blank;

    function automatic clt_pkg::bundle_t put_result(
        clt_pkg::bundle_t b,
        clt_pkg::kind_t   k,
        logic [7:0]       by,
        logic [5:0]       idx,
        logic [6:0]       cnt
    );
        clt_pkg::bundle_t r;
        r = b;
        r.res[r.count].kind        = k;
        r.res[r.count].tok_byte    = by;
        r.res[r.count].token_index = idx;
        r.res[r.count].token_count = cnt;
        r.count = r.count + 2'd1;
        return r;
    endfunction

    function automatic clt_pkg::mode_t limit_mode(logic [TW-1:0] t, clt_pkg::mode_t nm);
        return (t >= TW'(MAX_TOKENS)) ? clt_pkg::MODE_IGNORE : nm;
    endfunction

    always_comb
    begin
        blank = (ch <= clt_pkg::CH_SPACE) || ((ch > clt_pkg::CH_ASCII_MAX) && high_bytes_blank);
        mode_next  = mode_reg;
        slash_next = slash_reg;
        star_next  = star_reg;
        tsf_next   = tsf_reg;
        bundle     = '0;
        do_bare    = 1'b0;

        if (line_end || (ch == 8'd0))
        begin
            if ((mode_reg == clt_pkg::MODE_BETWEEN) || (mode_reg == clt_pkg::MODE_BARE))
            begin
                if (slash_reg)
                begin
                    bundle = put_result(bundle, clt_pkg::KIND_BYTE, clt_pkg::CH_SLASH,
                                        6'(tsf_reg), 7'd0);
                    bundle = put_result(bundle, clt_pkg::KIND_END, 8'd0, 6'(tsf_reg), 7'd0);
                    tsf_next = tsf_reg + TW'(1);
                end
                else if (mode_reg == clt_pkg::MODE_BARE)
                begin
                    bundle = put_result(bundle, clt_pkg::KIND_END, 8'd0, 6'(tsf_reg), 7'd0);
                    tsf_next = tsf_reg + TW'(1);
                end
            end
            else if (mode_reg == clt_pkg::MODE_QUOTED)
            begin
                bundle = put_result(bundle, clt_pkg::KIND_END, 8'd0, 6'(tsf_reg), 7'd0);
                tsf_next = tsf_reg + TW'(1);
            end
            bundle = put_result(bundle, clt_pkg::KIND_DONE, 8'd0, 6'd0, 7'(tsf_next));
            mode_next  = clt_pkg::MODE_BETWEEN;
            slash_next = 1'b0;
            star_next  = 1'b0;
            tsf_next   = '0;
        end
        else
        begin
            case (mode_reg)
                clt_pkg::MODE_BETWEEN:
                begin
                    if (slash_reg)
                    begin
                        slash_next = 1'b0;
                        if (ch == clt_pkg::CH_SLASH)
                        begin
                            mode_next = clt_pkg::MODE_IGNORE;
                        end
                        else if (ch == clt_pkg::CH_STAR)
                        begin
                            mode_next = clt_pkg::MODE_COMMENT;
                            star_next = 1'b1;
                        end
                        else
                        begin
                            mode_next = clt_pkg::MODE_BARE;
                            bundle = put_result(bundle, clt_pkg::KIND_BYTE, clt_pkg::CH_SLASH,
                                                6'(tsf_reg), 7'd0);
                            do_bare = 1'b1;
                        end
                    end
                    else if (!blank)
                    begin
                        if (ch == clt_pkg::CH_SLASH)
                        begin
                            slash_next = 1'b1;
                        end
                        else if (ch == clt_pkg::CH_QUOTE)
                        begin
                            mode_next = clt_pkg::MODE_QUOTED;
                        end
                        else
                        begin
                            mode_next = clt_pkg::MODE_BARE;
                            bundle = put_result(bundle, clt_pkg::KIND_BYTE, ch,
                                                6'(tsf_reg), 7'd0);
                        end
                    end
                end
                clt_pkg::MODE_BARE:
                begin
                    if (slash_reg)
                    begin
                        slash_next = 1'b0;
                        if ((ch == clt_pkg::CH_SLASH) || (ch == clt_pkg::CH_STAR))
                        begin
                            bundle = put_result(bundle, clt_pkg::KIND_END, 8'd0,
                                                6'(tsf_reg), 7'd0);
                            tsf_next = tsf_reg + TW'(1);
                            if (ch == clt_pkg::CH_SLASH)
                            begin
                                mode_next = clt_pkg::MODE_IGNORE;
                            end
                            else
                            begin
                                mode_next = limit_mode(tsf_next, clt_pkg::MODE_COMMENT);
                                if (mode_next == clt_pkg::MODE_COMMENT)
                                begin
                                    star_next = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            bundle = put_result(bundle, clt_pkg::KIND_BYTE, clt_pkg::CH_SLASH,
                                                6'(tsf_reg), 7'd0);
                            do_bare = 1'b1;
                        end
                    end
                    else
                    begin
                        do_bare = 1'b1;
                    end
                end
                clt_pkg::MODE_QUOTED:
                begin
                    if (ch == clt_pkg::CH_QUOTE)
                    begin
                        bundle = put_result(bundle, clt_pkg::KIND_END, 8'd0, 6'(tsf_reg), 7'd0);
                        tsf_next  = tsf_reg + TW'(1);
                        mode_next = limit_mode(tsf_next, clt_pkg::MODE_BETWEEN);
                    end
                    else
                    begin
                        bundle = put_result(bundle, clt_pkg::KIND_BYTE, ch, 6'(tsf_reg), 7'd0);
                    end
                end
                clt_pkg::MODE_COMMENT:
                begin
                    if (star_reg && (ch == clt_pkg::CH_SLASH))
                    begin
                        star_next = 1'b0;
                        mode_next = clt_pkg::MODE_BETWEEN;
                    end
                    else
                    begin
                        star_next = (ch == clt_pkg::CH_STAR);
                    end
                end
                default:
                begin
                end
            endcase

            if (do_bare)
            begin
                if (blank || (ch == clt_pkg::CH_QUOTE))
                begin
                    bundle = put_result(bundle, clt_pkg::KIND_END, 8'd0, 6'(tsf_reg), 7'd0);
                    tsf_next  = tsf_reg + TW'(1);
                    mode_next = limit_mode(tsf_next,
                                           blank ? clt_pkg::MODE_BETWEEN : clt_pkg::MODE_QUOTED);
                end
                else if (ch == clt_pkg::CH_SLASH)
                begin
                    slash_next = 1'b1;
                end
                else
                begin
                    bundle = put_result(bundle, clt_pkg::KIND_BYTE, ch, 6'(tsf_reg), 7'd0);
                end
            end
        end
    end

    assign bundle_valid = accept && (bundle.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= clt_pkg::MODE_BETWEEN;
            slash_reg <= 1'b0;
            star_reg  <= 1'b0;
            tsf_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            slash_reg <= slash_next;
            star_reg  <= star_next;
            tsf_reg   <= tsf_next;
        end
    end

endmodule

### src/clt_fifo.sv
module clt_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  clt_pkg::bundle_t   push_data,
    output logic               full,
    input  logic               pop,
    output clt_pkg::bundle_t   head,
    output logic               empty
);

    localparam int DEPTH = clt_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    clt_pkg::bundle_t   mem_reg [DEPTH];
    logic [AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]      count_reg;
    logic               do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

### src/clt_back.sv
module clt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  clt_pkg::bundle_t   head,
    input  logic               head_valid,
    output logic               head_pop,
    output clt_pkg::result_t   out_res,
    output logic               out_last,
    output logic               out_valid,
    input  logic               out_pop
);

    logic [1:0]         pos_reg;
    logic               valid_reg;
    clt_pkg::result_t   res_reg;
    logic               last_reg;
    logic               load;
    logic               is_last;

    assign load     = head_valid && (!valid_reg || out_pop);
    assign is_last  = (pos_reg == (head.count - 2'd1));
    assign head_pop = load && is_last;

    assign out_res   = res_reg;
    assign out_last  = last_reg;
    assign out_valid = valid_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= head.res[pos_reg];
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                pos_reg   <= is_last ? 2'd0 : pos_reg + 2'd1;
            end
            else if (out_pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

### src/command_line_tokenizer.sv
// Command line tokenizer. Bytes of one line enter on ch (line_end or a zero byte closes the
// line) and leave as a stream of results: token bytes, token ends and one line-done beat that
// carries the token count. A byte is accepted every cycle while the four-entry queue between
// the scanner and the result serializer has room; one byte yields zero to three results, and
// the result side delivers one result per cycle while results are popped. A result passes
// through the queue and then the serializer's output register before it appears. Register
// high_bytes_blank (address 0) selects whether bytes above 127 separate tokens; write it
// only while the block is idle.
module command_line_tokenizer #(
    parameter int MAX_TOKENS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [7:0]   ch,
    input  logic         line_end,
    output logic         empty,
    input  logic         pop,
    output logic [1:0]   kind,
    output logic [7:0]   tok_byte,
    output logic [5:0]   token_index,
    output logic [6:0]   token_count,
    output logic         last_of_run,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic               hbb_reg;
    logic               accept;
    logic               bundle_valid;
    clt_pkg::bundle_t   bundle;
    clt_pkg::bundle_t   head;
    logic               queue_empty;
    logic               head_pop;
    clt_pkg::result_t   out_res;
    logic               out_valid;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == clt_pkg::REG_HIGH_BYTES_BLANK) ? {31'd0, hbb_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hbb_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[2] == clt_pkg::REG_HIGH_BYTES_BLANK))
        begin
            hbb_reg <= pwdata[0];
        end
    end

    assign accept = push && !full;

    clt_front #(
        .MAX_TOKENS(MAX_TOKENS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .high_bytes_blank (hbb_reg),
        .accept           (accept),
        .ch               (ch),
        .line_end         (line_end),
        .bundle_valid     (bundle_valid),
        .bundle           (bundle)
    );

    clt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (bundle_valid),
        .push_data (bundle),
        .full      (full),
        .pop       (head_pop),
        .head      (head),
        .empty     (queue_empty)
    );

    clt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!queue_empty),
        .head_pop   (head_pop),
        .out_res    (out_res),
        .out_last   (last_of_run),
        .out_valid  (out_valid),
        .out_pop    (pop)
    );

    assign empty       = !out_valid;
    assign kind        = out_res.kind;
    assign tok_byte    = out_res.tok_byte;
    assign token_index = out_res.token_index;
    assign token_count = out_res.token_count;

endmodule

### tb/clt_result_checker.sv
module clt_result_checker
    import clt_pkg::*;
#(
    parameter int MAX_TOKENS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic         full,
    input  logic [7:0]   ch,
    input  logic         line_end,
    input  logic         empty,
    input  logic         pop,
    input  logic [1:0]   kind,
    input  logic [7:0]   tok_byte,
    input  logic [5:0]   token_index,
    input  logic [6:0]   token_count,
    input  logic         last_of_run,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic         pready,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output int           fail_count,
    output int           beats_owed
);

    typedef struct packed {
        result_t res;
        logic    last;
    } token_beat_t;

    mode_t         scan_mode;
    logic          slash_held;
    logic          star_seen;
    logic          hi_blank;
    int unsigned   tok_cnt;
    token_beat_t   step_beats[$];
    token_beat_t   owed_beats[$];

    initial fail_count = 0;
    initial beats_owed = 0;

    function automatic void emit(kind_t k, logic [7:0] b, int unsigned idx, int unsigned cnt);
        token_beat_t t;
        if (step_beats.size() >= MAX_RESULTS)
            return;
        t.res.kind        = k;
        t.res.tok_byte    = b;
        t.res.token_index = 6'(idx);
        t.res.token_count = 7'(cnt);
        t.last            = 1'b0;
        step_beats.push_back(t);
    endfunction

    function automatic bit is_sep(logic [7:0] c);
        return (c <= CH_SPACE) || ((c > CH_ASCII_MAX) && hi_blank);
    endfunction

    function automatic void close_token(mode_t nxt);
        emit(KIND_END, 8'h00, tok_cnt, 0);
        tok_cnt++;
        scan_mode = (tok_cnt >= MAX_TOKENS) ? MODE_IGNORE : nxt;
    endfunction

    function automatic void bare_byte(logic [7:0] c);
        if (is_sep(c))
            close_token(MODE_BETWEEN);
        else if (c == CH_QUOTE)
            close_token(MODE_QUOTED);
        else if (c == CH_SLASH)
            slash_held = 1'b1;
        else
            emit(KIND_BYTE, c, tok_cnt, 0);
    endfunction

    function automatic void gap_byte(logic [7:0] c);
        if (is_sep(c))
            return;
        if (c == CH_SLASH)
            slash_held = 1'b1;
        else if (c == CH_QUOTE)
            scan_mode = MODE_QUOTED;
        else
        begin
            scan_mode = MODE_BARE;
            emit(KIND_BYTE, c, tok_cnt, 0);
        end
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        case (scan_mode)
            MODE_BETWEEN:
            begin
                if (slash_held)
                begin
                    slash_held = 1'b0;
                    if (c == CH_SLASH)
                        scan_mode = MODE_IGNORE;
                    else if (c == CH_STAR)
                    begin
                        scan_mode = MODE_COMMENT;
                        star_seen = 1'b1;
                    end
                    else
                    begin
                        scan_mode = MODE_BARE;
                        emit(KIND_BYTE, CH_SLASH, tok_cnt, 0);
                        bare_byte(c);
                    end
                end
                else
                    gap_byte(c);
            end
            MODE_BARE:
            begin
                if (slash_held)
                begin
                    slash_held = 1'b0;
                    if (c == CH_SLASH)
                        close_token(MODE_IGNORE);
                    else if (c == CH_STAR)
                    begin
                        close_token(MODE_COMMENT);
                        if (scan_mode == MODE_COMMENT)
                            star_seen = 1'b1;
                    end
                    else
                    begin
                        emit(KIND_BYTE, CH_SLASH, tok_cnt, 0);
                        bare_byte(c);
                    end
                end
                else
                    bare_byte(c);
            end
            MODE_QUOTED:
            begin
                if (c == CH_QUOTE)
                    close_token(MODE_BETWEEN);
                else
                    emit(KIND_BYTE, c, tok_cnt, 0);
            end
            MODE_COMMENT:
            begin
                if (star_seen && c == CH_SLASH)
                begin
                    star_seen = 1'b0;
                    scan_mode = MODE_BETWEEN;
                end
                else
                    star_seen = (c == CH_STAR);
            end
            default:
                ;
        endcase
    endfunction

    function automatic void clear_line();
        scan_mode  = MODE_BETWEEN;
        slash_held = 1'b0;
        star_seen  = 1'b0;
        tok_cnt    = 0;
    endfunction

    function automatic void close_line();
        if (scan_mode == MODE_BETWEEN || scan_mode == MODE_BARE)
        begin
            if (slash_held)
            begin
                emit(KIND_BYTE, CH_SLASH, tok_cnt, 0);
                close_token(MODE_BETWEEN);
            end
            else if (scan_mode == MODE_BARE)
                close_token(MODE_BETWEEN);
        end
        else if (scan_mode == MODE_QUOTED)
            close_token(MODE_BETWEEN);
        emit(KIND_DONE, 8'h00, 0, tok_cnt);
        clear_line();
    endfunction

    function automatic void predict_beats(logic [7:0] c, logic e);
        step_beats.delete();
        if (e || c == 8'h00)
            close_line();
        else
            scan_byte(c);
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].last = 1'b1;
        foreach (step_beats[i])
            owed_beats.push_back(step_beats[i]);
    endfunction

    always @(posedge clk)
    begin : watch
        token_beat_t want;
        if (!rst_n)
        begin
            clear_line();
            hi_blank = 1'b1;
            owed_beats.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (owed_beats.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected beat kind %0d byte %02h index %0d count %0d",
                                 $time, kind, tok_byte, token_index, token_count);
                    fail_count++;
                end
                else
                begin
                    want = owed_beats.pop_front();
                    if (kind != want.res.kind || tok_byte != want.res.tok_byte ||
                        token_index != want.res.token_index ||
                        token_count != want.res.token_count || last_of_run != want.last)
                    begin
                        if (fail_count < 10)
                        begin
                            $write("%0t: beat error, want kind %0d byte %02h index %0d ",
                                   $time, want.res.kind, want.res.tok_byte,
                                   want.res.token_index);
                            $write("count %0d last %0b, ", want.res.token_count, want.last);
                            $display("got kind %0d byte %02h index %0d count %0d last %0b",
                                     kind, tok_byte, token_index, token_count, last_of_run);
                        end
                        fail_count++;
                    end
                end
            end
            if (push && !full)
                predict_beats(ch, line_end);
            if (psel && penable && pwrite && pready &&
                paddr == {REG_HIGH_BYTES_BLANK, 2'b00})
                hi_blank = pwdata[0];
        end
        beats_owed <= owed_beats.size();
    end

endmodule

### tb/tb_command_line_tokenizer.sv
module tb_command_line_tokenizer;
    import clt_pkg::*;

    localparam int TOKEN_LIMIT = 64;
    localparam int DRAIN_SLACK = 8;

    logic         clk;
    logic         rst_n = 1'b0;
    logic         push = 1'b0;
    logic         full;
    logic [7:0]   ch = 8'h00;
    logic         line_end = 1'b0;
    logic         empty;
    logic         pop = 1'b0;
    logic [1:0]   kind;
    logic [7:0]   tok_byte;
    logic [5:0]   token_index;
    logic [6:0]   token_count;
    logic         last_of_run;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = 3'b000;
    logic [31:0]  pwdata = 32'h0;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count;
    int           beats_owed;

    int           idle_pct = 36;
    int           beats_sent = 0;

    command_line_tokenizer #(.MAX_TOKENS(TOKEN_LIMIT)) dut (.*);

    clt_result_checker #(.MAX_TOKENS(TOKEN_LIMIT)) checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
        pop <= ($urandom_range(99) >= idle_pct);

    task automatic send_beat(input logic [7:0] b, input logic e);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push     <= 1'b1;
        ch       <= b;
        line_end <= e;
        do
            @(posedge clk);
        while (full);
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (beats_owed != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [7:0] rand_glyph();
        case ($urandom_range(9))
            0:       return CH_SLASH;
            1:       return CH_STAR;
            2:       return 8'($urandom_range(255, 128));
            default: return 8'($urandom_range(126, 33));
        endcase
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(3))
            0, 1:    return CH_SPACE;
            2:       return 8'($urandom_range(32, 1));
            default: return 8'($urandom_range(255, 128));
        endcase
    endfunction

    task automatic end_line();
        if ($urandom_range(1) != 0)
            send_beat(8'($urandom_range(255)), 1'b1);
        else
            send_beat(8'h00, 1'b0);
    endtask

    task automatic rand_line();
        int ntok;
        ntok = $urandom_range(6);
        for (int t = 0; t < ntok; t++)
        begin
            if ($urandom_range(2) != 0)
                repeat ($urandom_range(2, 1)) send_beat(rand_blank(), 1'b0);
            case ($urandom_range(9))
                0, 1, 2, 3:
                    repeat ($urandom_range(5, 1)) send_beat(rand_glyph(), 1'b0);
                4, 5:
                begin
                    send_beat(CH_QUOTE, 1'b0);
                    repeat ($urandom_range(4)) send_beat(8'($urandom_range(255, 1)), 1'b0);
                    if ($urandom_range(3) != 0)
                        send_beat(CH_QUOTE, 1'b0);
                end
                6, 7:
                begin
                    send_text("/*");
                    repeat ($urandom_range(3)) send_beat(rand_glyph(), 1'b0);
                    send_text("*/");
                end
                8:
                begin
                    send_text("//");
                    repeat ($urandom_range(3)) send_beat(rand_glyph(), 1'b0);
                end
                default:
                begin
                    send_beat(CH_SLASH, 1'b0);
                    send_beat(rand_glyph(), 1'b0);
                end
            endcase
        end
        if ($urandom_range(3) == 0)
            send_beat(CH_SLASH, 1'b0);
        end_line();
    endtask

    task automatic noise_line();
        repeat ($urandom_range(12, 1)) send_beat(8'($urandom_range(255)), 1'b0);
        end_line();
    endtask

    // overrun the token limit, then feed text that must be dropped
    task automatic limit_line();
        repeat (TOKEN_LIMIT + 2)
        begin
            send_beat(8'($urandom_range(122, 97)), 1'b0);
            send_beat(CH_SPACE, 1'b0);
        end
        send_text("x \"y\" /*");
        end_line();
    endtask

    initial
    begin
        int target;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(8'hFF, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(CH_ASCII_MAX, 1'b0);
        send_beat(8'h21, 1'b0);
        send_beat(CH_SPACE, 1'b0);
        send_beat(8'h01, 1'b0);
        send_text("\"/*\"\"\"a/b\"c");
        send_beat(8'hFF, 1'b1);

        send_text("x");
        settle();
        reg_write(REG_HIGH_BYTES_BLANK, 32'h0);
        send_beat(8'h80, 1'b0);
        send_text("/*//");
        send_beat(8'h00, 1'b1);

        send_text("k//m");
        send_beat(8'h00, 1'b0);

        send_text("/*q");
        send_beat(CH_STAR, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            reg_write(REG_HIGH_BYTES_BLANK, 32'((ph + 1) % 2));
            idle_pct = (ph == 2) ? 0 : 36;
            target = beats_sent + 50;
            if (ph == 1)
                limit_line();
            while (beats_sent < target)
            begin
                if ($urandom_range(9) == 0)
                    noise_line();
                else
                    rand_line();
            end
        end

        settle();
        if (fail_count == 0 && beats_owed == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
